FILE: hdl/lom_pkg.sv
// Package for the limit order matcher: transfer structs, result kinds, FSM states.
// No dependencies.
package lom_pkg;

    localparam int PRICE_W = 31;
    localparam int QTY_W   = 24;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_FILL    = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_PARTIAL = 3'd2,
        KIND_UNEXEC  = 3'd3,
        KIND_DROPPED = 3'd4
    } kind_t;

    typedef struct packed {
        logic              side_is_buy;
        logic [PRICE_W-1:0] limit_price;
        logic [QTY_W-1:0]   order_quantity;
        logic [TIME_W-1:0]  order_time;
    } order_t;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [QTY_W-1:0]   fill_quantity;
        logic [PRICE_W-1:0] fill_price;
        logic [QTY_W-1:0]   remaining_quantity;
        logic               last_result;
    } result_t;

    // One book entry as stored in memory
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [TIME_W-1:0]  tstamp;
    } entry_t;

    localparam int ENTRY_W = PRICE_W + QTY_W + TIME_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_MATCH_RD,
        ST_MATCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_STATUS
    } state_t;

endpackage

FILE: hdl/limit_order_matcher.sv
// Limit order matcher top level: sequencer, two book RAMs and shared compare.
// Depends on lom_pkg, lom_ram, lom_cmp.
//
// One order is taken when start is high and busy is low; busy then stays high
// until the final status result is on the ports. Each fill costs a scan of the
// opposite side: ST_SCAN_RD starts it, ST_SCAN_CMP takes each stored entry in
// turn through the registered RAM read, then ST_MATCH_RD and ST_MATCH settle and
// test the best entry. Removing a fully filled entry shifts each later entry down
// through ST_SHIFT_RD and ST_SHIFT_WR. ST_STATUS makes the final status, and each
// result is registered and shows up in the cycle after the state that makes it.
// A zero quantity or an empty opposite side goes straight to ST_STATUS. Results
// appear for one cycle with strobe high and cannot be stalled.
module limit_order_matcher
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  order_t  order,
    output logic    busy,
    output logic    strobe,
    output result_t result
);

    localparam int AW = $clog2(BOOK_DEPTH);
    localparam int CW = $clog2(BOOK_DEPTH + 1);

    state_t state_reg, state_next;
    order_t ord_reg, ord_next;
    logic [QTY_W-1:0] qty_reg, qty_next;
    logic [CW-1:0] bid_cnt_reg, bid_cnt_next, ask_cnt_reg, ask_cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] best_reg, best_next;
    entry_t best_e_reg, best_e_next;
    logic strobe_reg, strobe_next;
    result_t res_reg, res_next;

    // RAM ports
    logic          bid_we, ask_we;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data;
    entry_t        bid_rd, ask_rd, opp_rd;
    logic          better;

    lom_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_bid (
        .clk(clk), .wr_en(bid_we), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(bid_rd)
    );

    lom_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_ask (
        .clk(clk), .wr_en(ask_we), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(ask_rd)
    );

    assign opp_rd = ord_reg.side_is_buy ? ask_rd : bid_rd;

    lom_cmp u_cmp (
        .want_high (!ord_reg.side_is_buy),
        .cand_price(opp_rd.price),
        .cand_time (opp_rd.tstamp),
        .best_price(best_e_reg.price),
        .best_time (best_e_reg.tstamp),
        .better    (better)
    );

    // Hold state and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bid_cnt_reg <= '0;
            ask_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bid_cnt_reg <= bid_cnt_next;
            ask_cnt_reg <= ask_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ord_reg    <= ord_next;
        qty_reg    <= qty_next;
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        best_e_reg <= best_e_next;
        res_reg    <= res_next;
    end

    logic [CW-1:0] opp_cnt, own_cnt;
    logic          crosses;

    assign opp_cnt = ord_reg.side_is_buy ? ask_cnt_reg : bid_cnt_reg;
    assign own_cnt = ord_reg.side_is_buy ? bid_cnt_reg : ask_cnt_reg;
    assign crosses = ord_reg.side_is_buy ? (best_e_reg.price <= ord_reg.limit_price)
                                         : (best_e_reg.price >= ord_reg.limit_price);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        ord_next     = ord_reg;
        qty_next     = qty_reg;
        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        best_e_next  = best_e_reg;
        strobe_next  = 1'b0;
        res_next     = res_reg;
        bid_we       = 1'b0;
        ask_we       = 1'b0;
        wr_addr      = '0;
        wr_data      = best_e_reg;
        rd_addr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ord_next   = order;
                    qty_next   = order.order_quantity;
                    state_next = ST_SCAN_RD;
                end
            end
            // Start a best-entry scan, or finish when nothing to match
            ST_SCAN_RD:
            begin
                if (qty_reg == '0 || opp_cnt == '0)
                begin
                    state_next = ST_STATUS;
                end
                else
                begin
                    rd_addr    = '0;
                    idx_next   = '0;
                    best_next  = '0;
                    state_next = ST_SCAN_CMP;
                end
            end
            // Compare the entry read last cycle, issue the next read
            ST_SCAN_CMP:
            begin
                if (idx_reg == '0 || better)
                begin
                    best_e_next = opp_rd;
                    best_next   = idx_reg[AW-1:0];
                end
                if (idx_reg + 1'b1 < opp_cnt)
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_next[AW-1:0];
                end
                else
                begin
                    state_next = ST_MATCH_RD;
                end
            end
            ST_MATCH_RD:
            begin
                state_next = ST_MATCH;
            end
            // Trade against the best entry
            ST_MATCH:
            begin
                if (!crosses)
                begin
                    state_next = ST_STATUS;
                end
                else
                begin
                    strobe_next             = 1'b1;
                    res_next.result_kind    = KIND_FILL;
                    res_next.fill_price     = best_e_reg.price;
                    res_next.last_result    = 1'b0;
                    if (best_e_reg.qty > qty_reg)
                    begin
                        res_next.fill_quantity      = qty_reg;
                        res_next.remaining_quantity = '0;
                        qty_next    = '0;
                        wr_addr     = best_reg;
                        wr_data     = best_e_reg;
                        wr_data.qty = best_e_reg.qty - qty_reg;
                        bid_we      = !ord_reg.side_is_buy;
                        ask_we      = ord_reg.side_is_buy;
                        state_next  = ST_STATUS;
                    end
                    else
                    begin
                        res_next.fill_quantity      = best_e_reg.qty;
                        res_next.remaining_quantity = qty_reg - best_e_reg.qty;
                        qty_next   = qty_reg - best_e_reg.qty;
                        idx_next   = CW'(best_reg);
                        state_next = ST_SHIFT_RD;
                    end
                end
            end
            // Remove the entry by shifting later ones down
            ST_SHIFT_RD:
            begin
                if (idx_reg + 1'b1 < opp_cnt)
                begin
                    rd_addr    = AW'(idx_reg + 1'b1);
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    if (ord_reg.side_is_buy)
                    begin
                        ask_cnt_next = ask_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        bid_cnt_next = bid_cnt_reg - 1'b1;
                    end
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_WR:
            begin
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = opp_rd;
                bid_we     = !ord_reg.side_is_buy;
                ask_we     = ord_reg.side_is_buy;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SHIFT_RD;
            end
            // Final status and resting of any remainder
            ST_STATUS:
            begin
                strobe_next                 = 1'b1;
                res_next.fill_quantity      = '0;
                res_next.fill_price         = '0;
                res_next.remaining_quantity = qty_reg;
                res_next.last_result        = 1'b1;
                if (qty_reg == '0)
                begin
                    res_next.result_kind = KIND_FULL;
                end
                else if (own_cnt >= CW'(BOOK_DEPTH))
                begin
                    res_next.result_kind = KIND_DROPPED;
                end
                else
                begin
                    res_next.result_kind = (qty_reg != ord_reg.order_quantity)
                                           ? KIND_PARTIAL : KIND_UNEXEC;
                    wr_addr        = own_cnt[AW-1:0];
                    wr_data.price  = ord_reg.limit_price;
                    wr_data.qty    = qty_reg;
                    wr_data.tstamp = ord_reg.order_time;
                    bid_we         = ord_reg.side_is_buy;
                    ask_we         = !ord_reg.side_is_buy;
                    if (ord_reg.side_is_buy)
                    begin
                        bid_cnt_next = bid_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ask_cnt_next = ask_cnt_reg + 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

FILE: hdl/lom_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/lom_cmp.sv
// Shared compare unit: decides whether a candidate entry beats the current best.
// Depends on lom_pkg.
module lom_cmp
    import lom_pkg::*;
(
    input  logic               want_high,
    input  logic [PRICE_W-1:0] cand_price,
    input  logic [TIME_W-1:0]  cand_time,
    input  logic [PRICE_W-1:0] best_price,
    input  logic [TIME_W-1:0]  best_time,
    output logic               better
);

    // Price first, earlier time breaks ties
    always_comb
    begin
        if (cand_price != best_price)
        begin
            better = want_high ? (cand_price > best_price) : (cand_price < best_price);
        end
        else
        begin
            better = cand_time < best_time;
        end
    end

endmodule
